/* rtl/chroma_key_alpha_core_defines.svh */
// ---------------------------------------------------------------------------
// chroma_key_alpha_core_defines.svh
// Assertion macros shared by the chroma key checker
// ---------------------------------------------------------------------------
`ifndef CHROMA_KEY_ALPHA_CORE_DEFINES_SVH
`define CHROMA_KEY_ALPHA_CORE_DEFINES_SVH

// same-cycle implication, disabled while reset is active
`define CKA_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is active
`define CKA_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/cka_pkg.sv */
// ---------------------------------------------------------------------------
// cka_pkg
// Types, codes and constants shared by the chroma key alpha matte block
// ---------------------------------------------------------------------------
package cka_pkg;

    localparam int BYTE_W = 8;
    localparam int DIV_W  = 9;
    localparam int DIST_W = 18;
    localparam int SQ_W   = 16;
    localparam int PROD_W = 26;
    localparam int IDX_W  = 3;
    localparam int FMT_W  = 3;

    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [BYTE_W-1:0] FILL_FULL = 8'd255;
    localparam logic [BYTE_W-1:0] FILL_MID  = 8'd128;

    // pixel format codes, code 7 is unused and treated as rgb24
    typedef enum logic [FMT_W-1:0] {
        FMT_RGB24    = 3'd0,
        FMT_BGR24    = 3'd1,
        FMT_RGBA32   = 3'd2,
        FMT_BGRA32   = 3'd3,
        FMT_YUV444   = 3'd4,
        FMT_YUVA4444 = 3'd5,
        FMT_YUYV422  = 3'd6
    } fmt_t;

    // configuration register indexes
    typedef enum logic [IDX_W-1:0] {
        REG_KEY_C0          = 3'd0,
        REG_KEY_C1          = 3'd1,
        REG_KEY_C2          = 3'd2,
        REG_Y_DIVISOR       = 3'd3,
        REG_NEAR_THRESHOLD  = 3'd4,
        REG_BLEND_WIDTH     = 3'd5,
        REG_QUADRATIC_MODE  = 3'd6,
        REG_PIXEL_FORMAT    = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [BYTE_W-1:0] key_c0;
        logic [BYTE_W-1:0] key_c1;
        logic [BYTE_W-1:0] key_c2;
        logic [DIV_W-1:0]  y_divisor;
        logic [DIST_W-1:0] near_threshold;
        logic [DIST_W-1:0] blend_width;
        logic              quadratic_mode;
        logic [FMT_W-1:0]  pixel_format;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        key_c0:         8'd140,
        key_c1:         8'd200,
        key_c2:         8'd75,
        y_divisor:      9'd5,
        near_threshold: 18'd90,
        blend_width:    18'd30,
        quadratic_mode: 1'b0,
        pixel_format:   3'd0
    };

    // classified pixel handed from the front part to the back part
    typedef struct packed {
        logic [BYTE_W-1:0] b0;
        logic [BYTE_W-1:0] b1;
        logic [BYTE_W-1:0] b2;
        logic [BYTE_W-1:0] b3;
        logic              yuv;
        logic              pair;
        logic [BYTE_W-1:0] amax;
        logic [BYTE_W-1:0] d0;
        logic [BYTE_W-1:0] d1;
        logic [BYTE_W-1:0] d2;
    } px_item_t;

endpackage

/* rtl/cka_front.sv */
// ---------------------------------------------------------------------------
// cka_front
// Accepts pixels, decodes the format, forms channel differences and divides
// the luma difference in a bit-per-stage restoring divider
// ---------------------------------------------------------------------------
module cka_front (
    input  logic              clk,
    input  logic              rst_n,
    input  cka_pkg::cfg_t     cfg,
    input  logic              pixel_valid,
    output logic              pixel_ready,
    input  logic [7:0]        byte0,
    input  logic [7:0]        byte1,
    input  logic [7:0]        byte2,
    input  logic [7:0]        byte3,
    output logic              item_valid,
    input  logic              item_ready,
    output cka_pkg::px_item_t item
);
    import cka_pkg::*;

    localparam int DSTG = BYTE_W;

    logic              swap;
    logic              yuv;
    logic              pair;
    logic              has_alpha;
    logic [BYTE_W-1:0] y_avg;
    logic [BYTE_W-1:0] y_sel;
    logic [BYTE_W-1:0] k0_sel;
    logic [BYTE_W-1:0] k2_sel;
    logic [BYTE_W-1:0] c2_sel;
    logic [DIV_W-1:0]  ydiv;
    logic [DIV_W-1:0]  dvs;
    px_item_t          cap_item;
    logic              adv;

    logic [DSTG:0]     vld_reg;
    px_item_t          itm_reg [0:DSTG];
    logic [BYTE_W-1:0] rem_reg [0:DSTG-1];
    logic [DIV_W-1:0]  rem_sh [0:DSTG-1];
    logic [BYTE_W-1:0] rem_next [0:DSTG-1];
    logic [BYTE_W-1:0] quo_next [0:DSTG-1];
    px_item_t          itm_next [0:DSTG-1];

    function automatic logic [BYTE_W-1:0] absd(input logic [BYTE_W-1:0] a,
                                               input logic [BYTE_W-1:0] b);
        absd = (a > b) ? (a - b) : (b - a);
    endfunction

    // format decode, unused code falls back to rgb24
    always_comb
    begin
        swap      = cfg.pixel_format inside {FMT_BGR24, FMT_BGRA32};
        yuv       = cfg.pixel_format inside {FMT_YUV444, FMT_YUVA4444, FMT_YUYV422};
        pair      = cfg.pixel_format inside {FMT_YUYV422};
        has_alpha = cfg.pixel_format inside {FMT_RGBA32, FMT_BGRA32, FMT_YUVA4444};
    end

    // luma divisor, zero acts as one, rgb formats divide by one
    assign ydiv = (cfg.y_divisor == '0) ? DIV_W'(1) : cfg.y_divisor;
    assign dvs  = yuv ? ydiv : DIV_W'(1);

    // channel selection and differences for the incoming pixel
    always_comb
    begin
        y_avg  = {1'b0, byte0[BYTE_W-1:1]} + {1'b0, byte2[BYTE_W-1:1]};
        y_sel  = pair ? y_avg : byte0;
        k0_sel = swap ? cfg.key_c2 : cfg.key_c0;
        k2_sel = swap ? cfg.key_c0 : cfg.key_c2;
        c2_sel = pair ? byte3 : byte2;

        cap_item.b0   = byte0;
        cap_item.b1   = byte1;
        cap_item.b2   = byte2;
        cap_item.b3   = byte3;
        cap_item.yuv  = yuv;
        cap_item.pair = pair;
        cap_item.amax = has_alpha ? byte3 : FILL_FULL;
        cap_item.d0   = absd(y_sel, k0_sel);
        cap_item.d1   = absd(byte1, cfg.key_c1);
        cap_item.d2   = absd(c2_sel, k2_sel);
    end

    // one restoring step per stage, dividend shifts out of d0 as quotient shifts in
    always_comb
    begin
        for (int s = 0; s < DSTG; s++)
        begin
            rem_sh[s] = {rem_reg[s], itm_reg[s].d0[BYTE_W-1]};
            if (rem_sh[s] >= dvs)
            begin
                rem_next[s] = BYTE_W'(rem_sh[s] - dvs);
                quo_next[s] = {itm_reg[s].d0[BYTE_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[s] = BYTE_W'(rem_sh[s]);
                quo_next[s] = {itm_reg[s].d0[BYTE_W-2:0], 1'b0};
            end
            itm_next[s]    = itm_reg[s];
            itm_next[s].d0 = quo_next[s];
        end
    end

    // whole pipeline moves unless its last stage is held by the queue
    assign adv         = !vld_reg[DSTG] || item_ready;
    assign pixel_ready = adv;
    assign item_valid  = vld_reg[DSTG];
    assign item        = itm_reg[DSTG];

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[DSTG-1:0], pixel_valid};
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            itm_reg[0] <= cap_item;
            rem_reg[0] <= '0;
            for (int s = 0; s < DSTG; s++)
            begin
                itm_reg[s+1] <= itm_next[s];
            end
            for (int s = 0; s < DSTG-1; s++)
            begin
                rem_reg[s+1] <= rem_next[s];
            end
        end
    end

endmodule

/* rtl/cka_queue.sv */
// ---------------------------------------------------------------------------
// cka_queue
// Short first-in first-out queue between the front and back parts
// ---------------------------------------------------------------------------
module cka_queue #(
    parameter int DEPTH = cka_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  cka_pkg::px_item_t push_item,
    output logic              pop_valid,
    input  logic              pop_ready,
    output cka_pkg::px_item_t pop_item
);
    import cka_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    px_item_t         mem_reg [0:DEPTH-1];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (cnt_reg != CNT_W'(DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_item   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // pointer wrap and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

/* rtl/cka_back.sv */
// ---------------------------------------------------------------------------
// cka_back
// Forms the key distance, classifies it against the thresholds, divides the
// scaled band offset for alpha and drives the result register
// ---------------------------------------------------------------------------
module cka_back (
    input  logic              clk,
    input  logic              rst_n,
    input  cka_pkg::cfg_t     cfg,
    input  logic              item_valid,
    output logic              item_ready,
    input  cka_pkg::px_item_t item,
    output logic              matte_valid,
    input  logic              matte_ready,
    output logic [7:0]        out0,
    output logic [7:0]        out1,
    output logic [7:0]        out2,
    output logic [7:0]        out3,
    output logic [7:0]        out4,
    output logic [7:0]        out5,
    output logic [7:0]        out6,
    output logic [7:0]        out7,
    output logic              second_valid
);
    import cka_pkg::*;

    localparam int DSTG = BYTE_W;
    localparam int NSTG = 4 + DSTG;

    logic              adv;

    logic [NSTG-1:0]   vld_reg;
    px_item_t          itm_reg [0:NSTG-1];
    logic [SQ_W-1:0]   sq0_reg;
    logic [SQ_W-1:0]   sq1_reg;
    logic [SQ_W-1:0]   sq2_reg;
    logic [DIST_W-1:0] tot_reg;
    logic              near_c_reg;
    logic              band_c_reg;
    logic [DIST_W-1:0] excess_reg;
    logic [PROD_W-1:0] rem_reg [0:DSTG-1];
    logic [BYTE_W-1:0] quo_reg [0:DSTG];
    logic              near_reg [0:DSTG];
    logic              band_reg [0:DSTG];

    logic [SQ_W-1:0]   sq0_next;
    logic [SQ_W-1:0]   sq1_next;
    logic [SQ_W-1:0]   sq2_next;
    logic [DIST_W:0]   band_top;
    logic [PROD_W-1:0] sub_val [0:DSTG-1];
    logic [PROD_W-1:0] rem_next [0:DSTG-1];
    logic [BYTE_W-1:0] quo_next [0:DSTG-1];

    px_item_t          fin;
    logic [BYTE_W-1:0] alpha;
    logic              mv_reg;
    logic [BYTE_W-1:0] o0_reg, o1_reg, o2_reg, o3_reg, o4_reg, o5_reg, o6_reg, o7_reg;
    logic              sv_reg;
    logic [BYTE_W-1:0] o0_next, o1_next, o2_next, o3_next;
    logic [BYTE_W-1:0] o4_next, o5_next, o6_next, o7_next;
    logic              sv_next;

    assign adv        = !mv_reg || matte_ready;
    assign item_ready = adv;

    // per-channel terms, squared in quadratic mode
    always_comb
    begin
        if (cfg.quadratic_mode)
        begin
            sq0_next = SQ_W'(item.d0) * SQ_W'(item.d0);
            sq1_next = SQ_W'(item.d1) * SQ_W'(item.d1);
            sq2_next = SQ_W'(item.d2) * SQ_W'(item.d2);
        end
        else
        begin
            sq0_next = SQ_W'(item.d0);
            sq1_next = SQ_W'(item.d1);
            sq2_next = SQ_W'(item.d2);
        end
    end

    // upper edge of the blend band
    assign band_top = {1'b0, cfg.near_threshold} + {1'b0, cfg.blend_width};

    // restoring division of the scaled offset, one quotient bit per stage
    always_comb
    begin
        for (int s = 0; s < DSTG; s++)
        begin
            sub_val[s] = PROD_W'(cfg.blend_width) << (DSTG - 1 - s);
            if (rem_reg[s] >= sub_val[s])
            begin
                rem_next[s] = rem_reg[s] - sub_val[s];
                quo_next[s] = {quo_reg[s][BYTE_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[s] = rem_reg[s];
                quo_next[s] = {quo_reg[s][BYTE_W-2:0], 1'b0};
            end
        end
    end

    // result assembly from the last stage
    assign fin   = itm_reg[NSTG-1];
    assign alpha = band_reg[DSTG] ? quo_reg[DSTG] : fin.amax;

    always_comb
    begin
        o0_next = '0;
        o1_next = '0;
        o2_next = '0;
        o3_next = '0;
        o4_next = '0;
        o5_next = '0;
        o6_next = '0;
        o7_next = '0;
        sv_next = fin.pair;
        if (near_reg[DSTG])
        begin
            o0_next = FILL_FULL;
            o1_next = fin.yuv ? FILL_MID : FILL_FULL;
            o2_next = fin.yuv ? FILL_MID : FILL_FULL;
            if (fin.pair)
            begin
                o4_next = FILL_FULL;
                o5_next = FILL_MID;
                o6_next = FILL_MID;
            end
        end
        else if (fin.pair)
        begin
            o0_next = fin.b0;
            o1_next = fin.b1;
            o2_next = fin.b3;
            o3_next = alpha;
            o4_next = fin.b2;
            o5_next = fin.b1;
            o6_next = fin.b3;
            o7_next = alpha;
        end
        else
        begin
            o0_next = fin.b0;
            o1_next = fin.b1;
            o2_next = fin.b2;
            o3_next = alpha;
        end
    end

    // stage valid bits and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            mv_reg  <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NSTG-2:0], item_valid};
            mv_reg  <= vld_reg[NSTG-1];
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            itm_reg[0] <= item;
            for (int s = 1; s < NSTG; s++)
            begin
                itm_reg[s] <= itm_reg[s-1];
            end

            sq0_reg <= sq0_next;
            sq1_reg <= sq1_next;
            sq2_reg <= sq2_next;

            tot_reg <= DIST_W'(sq0_reg) + DIST_W'(sq1_reg) + DIST_W'(sq2_reg);

            near_c_reg <= (tot_reg < cfg.near_threshold);
            band_c_reg <= ({1'b0, tot_reg} < band_top);
            excess_reg <= tot_reg - cfg.near_threshold;

            rem_reg[0]  <= PROD_W'(itm_reg[2].amax) * PROD_W'(excess_reg);
            quo_reg[0]  <= '0;
            near_reg[0] <= near_c_reg;
            band_reg[0] <= band_c_reg;

            for (int s = 0; s < DSTG; s++)
            begin
                quo_reg[s+1]  <= quo_next[s];
                near_reg[s+1] <= near_reg[s];
                band_reg[s+1] <= band_reg[s];
            end
            for (int s = 0; s < DSTG-1; s++)
            begin
                rem_reg[s+1] <= rem_next[s];
            end

            o0_reg <= o0_next;
            o1_reg <= o1_next;
            o2_reg <= o2_next;
            o3_reg <= o3_next;
            o4_reg <= o4_next;
            o5_reg <= o5_next;
            o6_reg <= o6_next;
            o7_reg <= o7_next;
            sv_reg <= sv_next;
        end
    end

    assign matte_valid  = mv_reg;
    assign out0         = o0_reg;
    assign out1         = o1_reg;
    assign out2         = o2_reg;
    assign out3         = o3_reg;
    assign out4         = o4_reg;
    assign out5         = o5_reg;
    assign out6         = o6_reg;
    assign out7         = o7_reg;
    assign second_valid = sv_reg;

endmodule

/* rtl/chroma_key_alpha_core.sv */
// ---------------------------------------------------------------------------
// chroma_key_alpha_core
// Chroma key alpha matte generator: one pixel or one YUYV pair per unstalled cycle
// ---------------------------------------------------------------------------
// Pixels enter on the pixel channel (pixel_valid / pixel_ready, byte0..3)
// and mattes leave on the matte channel (matte_valid / matte_ready,
// out0..out7, second_valid). Both channels complete a transaction when
// valid and ready are high at a rising edge.
// Registers are written through the cfg channel (cfg_index, cfg_data);
// cfg_ready is always high and writes belong between frames, while no
// pixel is in flight.
// Throughput is one pixel per cycle while the matte channel does not stall.
// A pixel passes a 9-stage front (capture plus one stage per luma quotient
// bit), a queue entry and a 12-stage back (terms, sum, threshold compare,
// alpha multiply, one stage per alpha quotient bit) followed by the result
// register.
// When the receiver stalls, the whole back pipeline holds at once, the queue
// takes up to QUEUE_DEPTH transactions, and pixel_ready then drops as soon as
// a pixel waits in the last front stage; empty stages are not squeezed out.
// Reset empties every stage and the queue and loads the register defaults.
// ---------------------------------------------------------------------------
module chroma_key_alpha_core #(
    parameter int QUEUE_DEPTH = cka_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [cka_pkg::IDX_W-1:0]   cfg_index,
    input  logic [cka_pkg::DIST_W-1:0]  cfg_data,
    input  logic                        pixel_valid,
    output logic                        pixel_ready,
    input  logic [7:0]                  byte0,
    input  logic [7:0]                  byte1,
    input  logic [7:0]                  byte2,
    input  logic [7:0]                  byte3,
    output logic                        matte_valid,
    input  logic                        matte_ready,
    output logic [7:0]                  out0,
    output logic [7:0]                  out1,
    output logic [7:0]                  out2,
    output logic [7:0]                  out3,
    output logic [7:0]                  out4,
    output logic [7:0]                  out5,
    output logic [7:0]                  out6,
    output logic [7:0]                  out7,
    output logic                        second_valid
);
    import cka_pkg::*;

    cfg_t     cfg_reg;
    logic     fq_valid;
    logic     fq_ready;
    px_item_t fq_item;
    logic     qb_valid;
    logic     qb_ready;
    px_item_t qb_item;

    assign cfg_ready = 1'b1;

    // register file writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (reg_idx_t'(cfg_index))
                REG_KEY_C0:         cfg_reg.key_c0         <= cfg_data[BYTE_W-1:0];
                REG_KEY_C1:         cfg_reg.key_c1         <= cfg_data[BYTE_W-1:0];
                REG_KEY_C2:         cfg_reg.key_c2         <= cfg_data[BYTE_W-1:0];
                REG_Y_DIVISOR:      cfg_reg.y_divisor      <= cfg_data[DIV_W-1:0];
                REG_NEAR_THRESHOLD: cfg_reg.near_threshold <= cfg_data[DIST_W-1:0];
                REG_BLEND_WIDTH:    cfg_reg.blend_width    <= cfg_data[DIST_W-1:0];
                REG_QUADRATIC_MODE: cfg_reg.quadratic_mode <= cfg_data[0];
                REG_PIXEL_FORMAT:   cfg_reg.pixel_format   <= cfg_data[FMT_W-1:0];
                default:            cfg_reg                <= cfg_reg;
            endcase
        end
    end

    // front: decode and luma divide
    cka_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .byte0       (byte0),
        .byte1       (byte1),
        .byte2       (byte2),
        .byte3       (byte3),
        .item_valid  (fq_valid),
        .item_ready  (fq_ready),
        .item        (fq_item)
    );

    // decoupling queue
    cka_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_item  (fq_item),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_item   (qb_item)
    );

    // back: distance, thresholds, alpha
    cka_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .item_valid   (qb_valid),
        .item_ready   (qb_ready),
        .item         (qb_item),
        .matte_valid  (matte_valid),
        .matte_ready  (matte_ready),
        .out0         (out0),
        .out1         (out1),
        .out2         (out2),
        .out3         (out3),
        .out4         (out4),
        .out5         (out5),
        .out6         (out6),
        .out7         (out7),
        .second_valid (second_valid)
    );

endmodule

/* rtl/cka_checker.sv */
// ---------------------------------------------------------------------------
// cka_checker
// Port-level checks on the matte channel, bound to the top level
// ---------------------------------------------------------------------------
`include "chroma_key_alpha_core_defines.svh"

module cka_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       matte_valid,
    input logic       matte_ready,
    input logic [7:0] out0,
    input logic [7:0] out1,
    input logic [7:0] out2,
    input logic [7:0] out3,
    input logic [7:0] out4,
    input logic [7:0] out5,
    input logic [7:0] out6,
    input logic [7:0] out7,
    input logic       second_valid
);

    // stalled result stays valid and holds out0, out3, out7 and second_valid
    `CKA_ASSERT_NEXT(a_matte_hold, clk, rst_n, matte_valid && !matte_ready, matte_valid && $stable(out0) && $stable(out3) && $stable(out7) && $stable(second_valid), "matte changed while stalled")

    // single pixel leaves the second slot clear
    `CKA_ASSERT_NOW(a_second_clear, clk, rst_n, matte_valid && !second_valid, out4 == 8'd0 && out5 == 8'd0 && out6 == 8'd0 && out7 == 8'd0, "second pixel not cleared")

    // both pixels of a pair share chroma and alpha
    `CKA_ASSERT_NOW(a_pair_shared, clk, rst_n, matte_valid && second_valid, out1 == out5 && out2 == out6 && out3 == out7, "pair chroma or alpha differ")

endmodule

bind chroma_key_alpha_core cka_checker u_cka_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .matte_valid  (matte_valid),
    .matte_ready  (matte_ready),
    .out0         (out0),
    .out1         (out1),
    .out2         (out2),
    .out3         (out3),
    .out4         (out4),
    .out5         (out5),
    .out6         (out6),
    .out7         (out7),
    .second_valid (second_valid)
);
